// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

// next-cycle implication
`ifndef SYNTH
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/zcrs_pkg.sv =====
// ---------------------------------------------------------------------------
// zcrs_pkg
// shared types and codes of the zero-cross relay switcher
// ---------------------------------------------------------------------------
`default_nettype none

package zcrs_pkg;

  localparam int FUNC_W  = 2;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W  = 3;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ON   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_OFF  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REQUEST_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ON_DELAY        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFF_DELAY       = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] REQUEST_TIMEOUT_RST = 16'd100;
  localparam logic [CFG_W-1:0] ON_DELAY_RST        = 16'd0;
  localparam logic [CFG_W-1:0] OFF_DELAY_RST       = 16'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF         = 3'd0,
    MODE_WAIT_ON     = 3'd1,
    MODE_DELAYED_ON  = 3'd2,
    MODE_ON          = 3'd3,
    MODE_WAIT_OFF    = 3'd4,
    MODE_DELAYED_OFF = 3'd5
  } mode_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sync_level;
    logic              timeout_tick;
    logic              delay_tick;
  } in_item_t;

  typedef struct packed {
    logic              relay_drive;
    logic              sync_pulse;
    logic              relay_is_on;
    logic              relay_is_off;
    logic [MODE_W-1:0] mode_code;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] request_timeout;
    logic [CFG_W-1:0] on_delay;
    logic [CFG_W-1:0] off_delay;
  } cfg_t;

  // controller status seen by the top level
  typedef struct packed {
    mode_t mode;
    logic  relay;
  } st_t;

endpackage

`default_nettype wire

// ===== design/zcrs_in_if.sv =====
// ---------------------------------------------------------------------------
// zcrs_in_if
// tick channel: valid/ready plus request, sync level and tick strobes
// ---------------------------------------------------------------------------
`default_nettype none

interface zcrs_in_if;
  logic                        valid;
  logic                        ready;
  logic [zcrs_pkg::FUNC_W-1:0] func;
  logic                        sync_level;
  logic                        timeout_tick;
  logic                        delay_tick;

  modport source (output valid, output func, output sync_level, output timeout_tick,
                  output delay_tick, input ready);
  modport sink (input valid, input func, input sync_level, input timeout_tick,
                input delay_tick, output ready);
endinterface

`default_nettype wire

// ===== design/zcrs_out_if.sv =====
// ---------------------------------------------------------------------------
// zcrs_out_if
// result channel: valid/ready plus relay and status outputs
// ---------------------------------------------------------------------------
`default_nettype none

interface zcrs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        relay_drive;
  logic                        sync_pulse;
  logic                        relay_is_on;
  logic                        relay_is_off;
  logic [zcrs_pkg::MODE_W-1:0] mode_code;

  modport source (output valid, output relay_drive, output sync_pulse,
                  output relay_is_on, output relay_is_off, output mode_code, input ready);
  modport sink (input valid, input relay_drive, input sync_pulse,
                input relay_is_on, input relay_is_off, input mode_code, output ready);
endinterface

`default_nettype wire

// ===== design/zcrs_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// zcrs_cfg_regs
// configuration register file, write only
// ---------------------------------------------------------------------------
`default_nettype none

module zcrs_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [zcrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [zcrs_pkg::CFG_W-1:0]     cfg_wdata,
  output zcrs_pkg::cfg_t                      cfg
);
  import zcrs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_REQUEST_TIMEOUT: cfg_nxt.request_timeout = cfg_wdata;
        CFG_IDX_ON_DELAY:        cfg_nxt.on_delay        = cfg_wdata;
        CFG_IDX_OFF_DELAY:       cfg_nxt.off_delay       = cfg_wdata;
        default:                 cfg_nxt = cfg_r;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.request_timeout <= REQUEST_TIMEOUT_RST;
      cfg_r.on_delay        <= ON_DELAY_RST;
      cfg_r.off_delay       <= OFF_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

`default_nettype wire

// ===== design/zcrs_ctrl.sv =====
// ---------------------------------------------------------------------------
// zcrs_ctrl
// relay state machine, edge detector and saturating counters, one tick per step
// ---------------------------------------------------------------------------
`default_nettype none

module zcrs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire zcrs_pkg::in_item_t  item,
  input  wire zcrs_pkg::cfg_t      cfg,
  output zcrs_pkg::out_item_t      res,
  output zcrs_pkg::st_t            st
);
  import zcrs_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic             last_sync_r, last_sync_nxt;
  logic [CNT_W-1:0] tc_r, tc_nxt;
  logic [CNT_W-1:0] dc_r, dc_nxt;
  logic             relay_r, relay_nxt;

  mode_t            mode_req;
  logic [CNT_W-1:0] tc_req;
  logic [CNT_W-1:0] dc_tick;
  logic             sync_edge;

  function automatic logic in_on_group(input mode_t m);
    in_on_group = (m == MODE_WAIT_ON) || (m == MODE_DELAYED_ON) || (m == MODE_ON);
  endfunction

  function automatic logic in_off_group(input mode_t m);
    in_off_group = (m == MODE_WAIT_OFF) || (m == MODE_DELAYED_OFF) || (m == MODE_OFF);
  endfunction

  // counters and request
  always_comb begin
    tc_req  = tc_r;
    dc_tick = dc_r;
    if (item.timeout_tick && (tc_r != '0)) tc_req = tc_r - 1'b1;
    if (item.delay_tick && (dc_r != '1)) dc_tick = dc_r + 1'b1;
    mode_req = mode_r;
    if ((item.func == FUNC_ON) && !in_on_group(mode_r)) begin
      mode_req = MODE_WAIT_ON;
      tc_req   = cfg.request_timeout;
    end else if ((item.func == FUNC_OFF) && !in_off_group(mode_r)) begin
      mode_req = MODE_WAIT_OFF;
      tc_req   = cfg.request_timeout;
    end
  end

  assign sync_edge     = last_sync_r && !item.sync_level;
  assign last_sync_nxt = item.sync_level;
  assign tc_nxt        = tc_req;

  // next state
  always_comb begin
    mode_nxt  = mode_req;
    dc_nxt    = dc_tick;
    relay_nxt = relay_r;
    unique case (mode_req)
      MODE_OFF, MODE_ON: begin
      end
      MODE_WAIT_ON: begin
        if (sync_edge) begin
          mode_nxt = MODE_DELAYED_ON;
          dc_nxt   = '0;
        end
        if (tc_req == '0) begin
          relay_nxt = 1'b1;
          mode_nxt  = MODE_ON;
        end
      end
      MODE_DELAYED_ON: begin
        if (dc_tick > cfg.on_delay) begin
          relay_nxt = 1'b1;
          mode_nxt  = MODE_ON;
        end
      end
      MODE_WAIT_OFF: begin
        if (sync_edge) begin
          mode_nxt = MODE_DELAYED_OFF;
          dc_nxt   = '0;
        end
        if (tc_req == '0) begin
          relay_nxt = 1'b0;
          mode_nxt  = MODE_OFF;
        end
      end
      MODE_DELAYED_OFF: begin
        if (dc_tick > cfg.off_delay) begin
          relay_nxt = 1'b0;
          mode_nxt  = MODE_OFF;
        end
      end
      default: begin
        relay_nxt = 1'b0;
        mode_nxt  = MODE_OFF;
      end
    endcase
  end

  // outputs, taken after the update
  always_comb begin
    res.relay_drive  = relay_nxt;
    res.sync_pulse   = last_sync_nxt;
    res.relay_is_on  = in_on_group(mode_nxt);
    res.relay_is_off = in_off_group(mode_nxt);
    res.mode_code    = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      last_sync_r <= 1'b0;
      tc_r        <= '0;
      dc_r        <= '0;
      relay_r     <= 1'b0;
    end else if (step_en) begin
      mode_r      <= mode_nxt;
      last_sync_r <= last_sync_nxt;
      tc_r        <= tc_nxt;
      dc_r        <= dc_nxt;
      relay_r     <= relay_nxt;
    end
  end

  assign st.mode  = mode_r;
  assign st.relay = relay_r;
endmodule

`default_nettype wire

// ===== design/zero_cross_relay_switcher.sv =====
// Data path: a transferred tick is held in the input register; its result is
//   loaded into the output register as the state machine steps and is sent from there.
// Throughput: one tick per cycle unless out_ch stalls; the relay state update is a
//   single pass of short logic between the input register and the output register.
// Reset: rst_n synchronous, active low; relay open, mode off, counters zero,
//   request_timeout 100, on_delay 0, off_delay 0, both pipeline stages empty.
// ---------------------------------------------------------------------------
// zero_cross_relay_switcher
// zero-cross synchronized relay controller, one result per tick
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module zero_cross_relay_switcher (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  zcrs_in_if.sink                             in_ch,
  zcrs_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [zcrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [zcrs_pkg::CFG_W-1:0]     cfg_wdata
);
  import zcrs_pkg::*;

  // input stage
  in_item_t  s1_item_r;
  logic      s1_valid_r, s1_valid_nxt;

  // output stage
  out_item_t out_item_r;
  logic      out_valid_r, out_valid_nxt;

  // control
  logic      out_adv;   // output register free or being drained this cycle
  logic      s1_fire;   // tick moves from input register through the state machine
  logic      in_fire;   // transfer on the input channel

  cfg_t      cfg;
  out_item_t step_res;
  st_t       st;

  assign out_adv  = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // configuration registers
  zcrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // state machine, steps only when the tick advances into the output register
  zcrs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_fire),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (step_res),
    .st      (st)
  );

  // stage valids
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (s1_fire) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_fire) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.func         <= in_ch.func;
      s1_item_r.sync_level   <= in_ch.sync_level;
      s1_item_r.timeout_tick <= in_ch.timeout_tick;
      s1_item_r.delay_tick   <= in_ch.delay_tick;
    end
    if (s1_fire) begin
      out_item_r <= step_res;
    end
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.relay_drive  = out_item_r.relay_drive;
  assign out_ch.sync_pulse   = out_item_r.sync_pulse;
  assign out_ch.relay_is_on  = out_item_r.relay_is_on;
  assign out_ch.relay_is_off = out_item_r.relay_is_off;
  assign out_ch.mode_code    = out_item_r.mode_code;

  // relay only closes on entering on and only opens on entering off
  `ASSERT_IMPL(a_relay_on_mode, clk, rst_n, st.mode == MODE_ON, st.relay, "relay open in on mode")
  `ASSERT_IMPL(a_relay_off_mode, clk, rst_n, st.mode == MODE_OFF, !st.relay, "relay closed in off mode")
  // a stalled result must not let the state machine step
  `ASSERT_NEXT(a_stall_holds_state, clk, rst_n, out_valid_r && !out_ch.ready, $stable(st.mode) && $stable(st.relay), "state changed while result stalled")
  // every stepped tick lands in the output register
  `ASSERT_NEXT(a_step_gives_result, clk, rst_n, s1_fire, out_valid_r, "stepped tick lost")
endmodule

`default_nettype wire

// ===== sim/zero_cross_relay_switcher_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zero_cross_relay_switcher_test
// self-checking bench for the zero-cross relay switcher: a directed table
// (reset state, request codes, sync edges, timeout fallback, register
// extremes) followed by randomized phases with a mains-like sync wave under
// several register settings; every result transfer is compared field by field
// with a table value or an in-bench model of the relay state machine
// ---------------------------------------------------------------------------

module zero_cross_relay_switcher_test;

  import zcrs_pkg::*;

  // codes the package leaves unnamed
  localparam logic [FUNC_W-1:0]    FUNC_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam int PHASES         = 6;
  localparam int TICKS_PER_PHASE = 180;
  localparam int SETTLE_CYCLES  = 4;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]       reg_val;
    in_item_t               tick;
    logic                   typed;
    out_item_t              want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  zcrs_in_if  in_ch ();
  zcrs_out_if out_ch ();

  zero_cross_relay_switcher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // -------------------------------------------------------------------------
  // relay controller model: settings and state as they stand after reset
  // -------------------------------------------------------------------------
  cfg_t relay_cfg = '{request_timeout: REQUEST_TIMEOUT_RST,
                      on_delay:        ON_DELAY_RST,
                      off_delay:       OFF_DELAY_RST};
  mode_t          relay_mode   = MODE_OFF;
  logic           sync_seen    = 1'b0;
  logic [CNT_W-1:0] timeout_left = '0;
  logic [CNT_W-1:0] delay_ticks  = '0;
  logic           relay_closed = 1'b0;

  out_item_t pending_status[$];   // expected results, oldest first
  int        fault_count    = 0;
  int        ticks_sent     = 0;
  int        results_seen   = 0;
  int        relay_switches = 0;
  int        burst_left     = 0;

  dir_row_t  dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall guard against a hung handshake
  initial begin
    #3_000_000;
    $display("timeout at %0t with %0d results outstanding", $time, pending_status.size());
    $display("zero_cross_relay_switcher regression: fail");
    $finish;
  end

  function automatic logic in_on_group(mode_t m);
    return m == MODE_WAIT_ON || m == MODE_DELAYED_ON || m == MODE_ON;
  endfunction

  function automatic logic in_off_group(mode_t m);
    return m == MODE_WAIT_OFF || m == MODE_DELAYED_OFF || m == MODE_OFF;
  endfunction

  // one tick of the controller: counters, then request, then edge and mode
  function automatic out_item_t predict_relay(in_item_t it);
    out_item_t res;
    logic      falling;
    logic      was_closed;
    was_closed = relay_closed;

    // both counters saturate
    if (it.timeout_tick && timeout_left != '0)
      timeout_left = timeout_left - 1'b1;
    if (it.delay_tick && delay_ticks != '1)
      delay_ticks = delay_ticks + 1'b1;

    // a request only counts when the relay is not already headed that way
    if (it.func == FUNC_ON && !in_on_group(relay_mode)) begin
      relay_mode   = MODE_WAIT_ON;
      timeout_left = relay_cfg.request_timeout;
    end else if (it.func == FUNC_OFF && !in_off_group(relay_mode)) begin
      relay_mode   = MODE_WAIT_OFF;
      timeout_left = relay_cfg.request_timeout;
    end

    falling   = sync_seen && !it.sync_level;
    sync_seen = it.sync_level;

    case (relay_mode)
      MODE_OFF, MODE_ON: begin
      end
      MODE_WAIT_ON: begin
        if (falling) begin
          relay_mode  = MODE_DELAYED_ON;
          delay_ticks = '0;
        end
        // timeout wins even on the tick that saw the edge
        if (timeout_left == '0) begin
          relay_closed = 1'b1;
          relay_mode   = MODE_ON;
        end
      end
      MODE_DELAYED_ON: begin
        if (delay_ticks > relay_cfg.on_delay) begin
          relay_closed = 1'b1;
          relay_mode   = MODE_ON;
        end
      end
      MODE_WAIT_OFF: begin
        if (falling) begin
          relay_mode  = MODE_DELAYED_OFF;
          delay_ticks = '0;
        end
        if (timeout_left == '0) begin
          relay_closed = 1'b0;
          relay_mode   = MODE_OFF;
        end
      end
      MODE_DELAYED_OFF: begin
        if (delay_ticks > relay_cfg.off_delay) begin
          relay_closed = 1'b0;
          relay_mode   = MODE_OFF;
        end
      end
      default: begin
        relay_closed = 1'b0;
        relay_mode   = MODE_OFF;
      end
    endcase

    if (relay_closed != was_closed)
      relay_switches++;

    res.relay_drive  = relay_closed;
    res.sync_pulse   = sync_seen;
    res.relay_is_on  = in_on_group(relay_mode);
    res.relay_is_off = in_off_group(relay_mode);
    res.mode_code    = relay_mode;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // directed table rows
  // -------------------------------------------------------------------------
  function automatic dir_row_t tick_row(logic [FUNC_W-1:0] func, logic sync,
                                        logic tto, logic tdl);
    dir_row_t r;
    r.kind    = ROW_TICK;
    r.reg_idx = CFG_IDX_REQUEST_TIMEOUT;
    r.reg_val = '0;
    r.tick    = '{func: func, sync_level: sync, timeout_tick: tto, delay_tick: tdl};
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic dir_row_t checked_row(logic [FUNC_W-1:0] func, logic sync,
                                           logic tto, logic tdl, logic drive,
                                           logic pulse, logic is_on, logic is_off,
                                           mode_t m);
    dir_row_t r;
    r       = tick_row(func, sync, tto, tdl);
    r.typed = 1'b1;
    r.want  = '{relay_drive: drive, sync_pulse: pulse, relay_is_on: is_on,
                relay_is_off: is_off, mode_code: m};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    dir_row_t r;
    r         = tick_row(FUNC_NONE, 1'b0, 1'b0, 1'b0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // tick sender: bursts of random length separated by random gaps
  // -------------------------------------------------------------------------
  task automatic send_tick(in_item_t it, logic typed, out_item_t want);
    out_item_t predicted;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.func         <= it.func;
    in_ch.sync_level   <= it.sync_level;
    in_ch.timeout_tick <= it.timeout_tick;
    in_ch.delay_tick   <= it.delay_tick;
    do @(posedge clk); while (!in_ch.ready);
    // transfer happened at this edge
    predicted = predict_relay(it);
    pending_status.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  // stop sending and wait for every expected result plus a little slack
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IDX_REQUEST_TIMEOUT: relay_cfg.request_timeout = val;
      CFG_IDX_ON_DELAY:        relay_cfg.on_delay        = val;
      CFG_IDX_OFF_DELAY:       relay_cfg.off_delay       = val;
      default: begin
        // spare index: write is dropped by the block
      end
    endcase
    @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // result side: stall pattern reloaded when stall_age wraps, sometimes all ready
  // -------------------------------------------------------------------------
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [5:0]  stall_age     = '0;

  always @(posedge clk) begin
    if (stall_age == '0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = 16'hFFFF;
        1:       stall_pattern = 16'h0101 | 16'($urandom);
        default: stall_pattern = 16'($urandom) | 16'h0001;
      endcase
    end
    out_ch.ready  <= stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    stall_age     <= stall_age + 1'b1;
  end

  task automatic report_field(string name, int unsigned want_val, int unsigned got_val);
    if (want_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_val, got_val);
      fault_count++;
    end
  endtask

  // result transfers are compared against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual drive=%0b mode=%0d",
                 $time, out_ch.relay_drive, out_ch.mode_code);
        fault_count++;
      end else begin
        want = pending_status.pop_front();
        report_field("relay_drive",  32'(want.relay_drive),  32'(out_ch.relay_drive));
        report_field("sync_pulse",   32'(want.sync_pulse),   32'(out_ch.sync_pulse));
        report_field("relay_is_on",  32'(want.relay_is_on),  32'(out_ch.relay_is_on));
        report_field("relay_is_off", 32'(want.relay_is_off), 32'(out_ch.relay_is_off));
        report_field("mode_code",    32'(want.mode_code),    32'(out_ch.mode_code));
      end
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    in_item_t    it;
    int          pick;
    logic        wave_level;
    int          wave_left;
    logic [CFG_W-1:0] t_set, on_set, off_set;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_IDX_REQUEST_TIMEOUT;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_NONE;
    in_ch.sync_level   <= 1'b0;
    in_ch.timeout_tick <= 1'b0;
    in_ch.delay_tick   <= 1'b0;

    // reset settings: timeout 100, no delays
    // idle after reset
    dir_rows.push_back(checked_row(FUNC_NONE,  1'b0, 1'b0, 1'b0,
                                   1'b0, 1'b0, 1'b0, 1'b1, MODE_OFF));
    // unused request code does nothing, timeout counter clamps at zero
    dir_rows.push_back(checked_row(FUNC_SPARE, 1'b1, 1'b1, 1'b1,
                                   1'b0, 1'b1, 1'b0, 1'b1, MODE_OFF));
    // off request while already off is ignored
    dir_rows.push_back(checked_row(FUNC_OFF,   1'b1, 1'b0, 1'b0,
                                   1'b0, 1'b1, 1'b0, 1'b1, MODE_OFF));
    // synced on cycle: wait, falling edge, delay expiry
    dir_rows.push_back(tick_row(FUNC_ON,   1'b1, 1'b1, 1'b1));
    dir_rows.push_back(tick_row(FUNC_ON,   1'b0, 1'b0, 1'b0));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b0, 1'b0, 1'b1));
    // synced off cycle, delay held one tick without a strobe
    dir_rows.push_back(tick_row(FUNC_OFF,  1'b1, 1'b0, 1'b0));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b1, 1'b1, 1'b1));
    // zero timeout switches at once without waiting for sync
    dir_rows.push_back(cfg_row(CFG_IDX_REQUEST_TIMEOUT, 16'd0));
    dir_rows.push_back(checked_row(FUNC_ON,  1'b0, 1'b1, 1'b0,
                                   1'b1, 1'b0, 1'b1, 1'b0, MODE_ON));
    dir_rows.push_back(checked_row(FUNC_OFF, 1'b1, 1'b0, 1'b0,
                                   1'b0, 1'b1, 1'b0, 1'b1, MODE_OFF));
    // edge and timeout expiry landing on the same tick
    dir_rows.push_back(cfg_row(CFG_IDX_REQUEST_TIMEOUT, 16'd2));
    dir_rows.push_back(tick_row(FUNC_ON,   1'b1, 1'b0, 1'b0));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b1, 1'b1, 1'b0));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b0, 1'b1, 1'b0));
    // all registers at maximum: delayed states can only be left by a request
    dir_rows.push_back(cfg_row(CFG_IDX_REQUEST_TIMEOUT, 16'hFFFF));
    dir_rows.push_back(cfg_row(CFG_IDX_ON_DELAY,        16'hFFFF));
    dir_rows.push_back(cfg_row(CFG_IDX_OFF_DELAY,       16'hFFFF));
    dir_rows.push_back(tick_row(FUNC_OFF,  1'b1, 1'b1, 1'b1));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b0, 1'b1, 1'b1));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b1, 1'b1, 1'b1));
    dir_rows.push_back(tick_row(FUNC_ON,   1'b0, 1'b0, 1'b1));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b1, 1'b1, 1'b1));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b0, 1'b1, 1'b1));
    // spare register index must leave the settings alone
    dir_rows.push_back(cfg_row(CFG_IDX_SPARE,    16'hA5A5));
    dir_rows.push_back(cfg_row(CFG_IDX_ON_DELAY,  16'd3));
    dir_rows.push_back(cfg_row(CFG_IDX_OFF_DELAY, 16'd1));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b0, 1'b0, 1'b1));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b0, 1'b0, 1'b1));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b0, 1'b0, 1'b1));
    dir_rows.push_back(tick_row(FUNC_NONE, 1'b1, 1'b0, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_setting(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // randomized phases: requests riding on a mains-like sync square wave
    wave_level = 1'b0;
    wave_left  = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin t_set = '0;           on_set = '0;      off_set = '0;      end
        1:       begin t_set = 16'hFFFF;     on_set = 16'hFFFF; off_set = 16'hFFFF; end
        2:       begin t_set = 16'hFFFF;     on_set = '0;      off_set = '0;      end
        default: begin
          t_set   = CFG_W'($urandom_range(0, 12));
          on_set  = CFG_W'($urandom_range(0, 6));
          off_set = CFG_W'($urandom_range(0, 6));
        end
      endcase
      drain_results();
      write_setting(CFG_IDX_REQUEST_TIMEOUT, t_set);
      write_setting(CFG_IDX_ON_DELAY,        on_set);
      write_setting(CFG_IDX_OFF_DELAY,       off_set);

      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (wave_left == 0) begin
          wave_level = ~wave_level;
          wave_left  = $urandom_range(1, 5);
        end
        wave_left--;
        // occasional glitch on the detector input
        it.sync_level = ($urandom_range(0, 19) == 0) ? ~wave_level : wave_level;
        pick = $urandom_range(0, 99);
        if (pick < 8)
          it.func = FUNC_ON;
        else if (pick < 16)
          it.func = FUNC_OFF;
        else if (pick < 18)
          it.func = FUNC_SPARE;
        else
          it.func = FUNC_NONE;
        it.timeout_tick = 1'($urandom_range(0, 1));
        it.delay_tick   = ($urandom_range(0, 9) < 7);
        send_tick(it, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_status.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_status.size());
      fault_count += pending_status.size();
    end

    $display("covered %0d ticks (%0d results) over %0d register settings phases",
             ticks_sent, results_seen, PHASES);
    $display("relay changed state %0d times, %0d mismatches", relay_switches, fault_count);
    if (fault_count == 0) begin
      $display("zero_cross_relay_switcher regression: pass");
    end else begin
      $display("zero_cross_relay_switcher regression: fail");
    end
    $finish;
  end

endmodule
